/* hdl/rrts_pkg.sv */
// Shared types and constants for the round-robin time-slice scheduler.
package rrts_pkg;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_DONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DEAD     = 2'd0,
		ST_INACTIVE = 2'd1,
		ST_ACTIVE   = 2'd2,
		ST_WAITING  = 2'd3
	} ent_state_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_REPLACED = 2'd1,
		STAT_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_KERNEL = 2'd1,
		ACT_SWITCH = 2'd2,
		ACT_START  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SHIFT,
		FSM_TICK_RD,
		FSM_DONE
	} fsm_t;

	localparam logic [7:0] FORCED_EXPIRY = 8'd255;
	localparam logic [7:0] ID_LAST       = 8'd255;

	// Controller to datapath
	typedef struct packed {
		logic latch;      // capture command fields
		logic scan_init;  // begin id search
		logic scan_step;  // test next candidate id
		logic add_write;  // write new entry
		logic shift_step; // move one entry down
		logic shift_end;  // finish remove
		logic tick_eval;  // evaluate tick, update state
		logic done_set;   // set finished flag
	} ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic id_hit;     // requested / candidate id is live
		logic rm_valid;
		logic shift_last;
	} sts_t;

endpackage

/* hdl/rrts_datapath.sv */
// Task table, id search, compaction and tick evaluation.
module rrts_datapath #(
	parameter int SLOTS   = 8,
	parameter int PC_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rrts_pkg::ctl_t         ctl,
	output rrts_pkg::sts_t         sts,
	input  logic [7:0]             task_id,
	input  logic [7:0]             slice_len,
	input  logic [31:0]            entry_pc,
	input  logic [2:0]             slot,
	input  logic [31:0]            interrupted_pc,
	input  logic [31:0]            kernel_return_pc,
	output logic [1:0]             status,
	output logic [7:0]             assigned_id,
	output logic [1:0]             action,
	output logic [2:0]             from_slot,
	output logic [2:0]             to_slot,
	output logic [31:0]            resume_pc
);
	import rrts_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	ent_state_t          st_q   [SLOTS];
	logic [7:0]          id_q   [SLOTS];
	logic [7:0]          slc_q  [SLOTS];
	logic [PC_BITS-1:0]  pc_q   [SLOTS];
	logic [CW-1:0]       cnt_q;
	logic [SW-1:0]       cur_q;
	logic [7:0]          run_q;
	logic                fin_q;

	logic [7:0]          tid_q, tsl_q, cand_q;
	logic [PC_BITS-1:0]  epc_q, ipc_q;
	logic [SW-1:0]       rm_q, idx_q;
	logic                repl_q;

	logic [1:0]          status_q, action_q;
	logic [7:0]          aid_q;
	logic [2:0]          from_q, to_q;
	logic [31:0]         res_q;

	logic [7:0]          probe;
	logic                hit;
	logic [SW-1:0]       cur_eff, nxt;
	logic [CW-1:0]       nxt_w;

	// Live-id match over all slots
	always_comb begin
		probe = ctl.scan_init ? tid_q : cand_q;
		hit = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			if (CW'(i) < cnt_q && st_q[i] != ST_DEAD && id_q[i] == probe)
				hit = 1'b1;
	end

	always_comb begin
		cur_eff = (CW'(cur_q) < cnt_q) ? cur_q : '0;
		nxt_w   = CW'(cur_eff) + CW'(1);
		nxt     = (nxt_w >= cnt_q) ? '0 : nxt_w[SW-1:0];
	end

	assign sts.full       = (cnt_q >= CW'(SLOTS));
	assign sts.id_hit     = hit;
	assign sts.rm_valid   = (cnt_q != '0) && (CW'(rm_q) < cnt_q);
	assign sts.shift_last = (CW'(idx_q) + CW'(1) >= cnt_q);

	// Command field capture, candidate id search and shift index step
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			tid_q  <= task_id;
			tsl_q  <= slice_len;
			epc_q  <= PC_BITS'(entry_pc);
			ipc_q  <= PC_BITS'(interrupted_pc);
			rm_q   <= SW'(slot);
			idx_q  <= SW'(slot);
			repl_q <= 1'b0;
		end
		if (ctl.scan_init) begin
			cand_q <= hit ? 8'd1 : tid_q;
			repl_q <= hit;
		end else if (ctl.scan_step && hit) begin
			cand_q <= (cand_q == ID_LAST) ? 8'd0 : cand_q + 8'd1;
		end
		if (ctl.shift_step)
			idx_q <= idx_q + SW'(1);
	end

	// Resume pcs, no reset
	always_ff @(posedge clk) begin
		if (ctl.add_write && !sts.full)
			pc_q[cnt_q[SW-1:0]] <= epc_q;
		if (ctl.shift_step)
			pc_q[idx_q] <= pc_q[idx_q + SW'(1)];
		if (ctl.tick_eval && cnt_q != '0 && run_q >= slc_q[cur_eff] &&
		    !(nxt == cur_eff) && st_q[cur_eff] == ST_ACTIVE)
			pc_q[cur_eff] <= ipc_q;
	end

	// Table and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				st_q[i]  <= ST_DEAD;
				id_q[i]  <= '0;
				slc_q[i] <= '0;
			end
			cnt_q <= '0;
			cur_q <= '0;
			run_q <= '0;
			fin_q <= 1'b0;
			status_q <= '0;
			aid_q    <= '0;
			action_q <= '0;
			from_q   <= '0;
			to_q     <= '0;
			res_q    <= '0;
		end else begin
			if (ctl.latch) begin
				status_q <= STAT_OK;
				aid_q    <= '0;
				action_q <= ACT_NONE;
				from_q   <= '0;
				to_q     <= '0;
				res_q    <= '0;
			end
			if (ctl.add_write) begin
				if (sts.full) begin
					status_q <= STAT_FULL;
				end else begin
					st_q[cnt_q[SW-1:0]]  <= ST_INACTIVE;
					id_q[cnt_q[SW-1:0]]  <= probe;
					slc_q[cnt_q[SW-1:0]] <= tsl_q;
					cnt_q    <= cnt_q + CW'(1);
					status_q <= repl_q ? STAT_REPLACED : STAT_OK;
					aid_q    <= probe;
					to_q     <= 3'(cnt_q);
				end
			end
			if (ctl.shift_step) begin
				st_q[idx_q]  <= st_q[idx_q + SW'(1)];
				id_q[idx_q]  <= id_q[idx_q + SW'(1)];
				slc_q[idx_q] <= slc_q[idx_q + SW'(1)];
			end
			if (ctl.shift_end) begin
				st_q[SW'(cnt_q - CW'(1))]  <= ST_DEAD;
				id_q[SW'(cnt_q - CW'(1))]  <= '0;
				slc_q[SW'(cnt_q - CW'(1))] <= '0;
				cnt_q <= cnt_q - CW'(1);
				run_q <= FORCED_EXPIRY;
				if (rm_q < cur_q)
					cur_q <= cur_q - SW'(1);
				else if (rm_q == cur_q && CW'(cur_q) >= cnt_q - CW'(1))
					cur_q <= '0;
			end
			if (ctl.done_set)
				fin_q <= 1'b1;
			if (ctl.tick_eval) begin
				if (cnt_q == '0) begin
					action_q <= ACT_KERNEL;
					res_q    <= 32'(PC_BITS'(kernel_return_pc));
				end else if (run_q >= slc_q[cur_eff]) begin
					run_q <= '0;
					if (nxt == cur_eff && st_q[cur_eff] == ST_ACTIVE) begin
						cur_q    <= cur_eff;
						action_q <= ACT_NONE;
						res_q    <= 32'(ipc_q);
					end else if (st_q[cur_eff] == ST_ACTIVE) begin
						st_q[cur_eff] <= ST_WAITING;
						st_q[nxt]     <= ST_ACTIVE;
						cur_q    <= nxt;
						action_q <= ACT_SWITCH;
						from_q   <= 3'(cur_eff);
						to_q     <= 3'(nxt);
						res_q    <= 32'(pc_q[nxt]);
					end else begin
						st_q[cur_eff] <= ST_ACTIVE;
						cur_q    <= cur_eff;
						action_q <= ACT_START;
						to_q     <= 3'(cur_eff);
						res_q    <= 32'(pc_q[cur_eff]);
					end
				end else begin
					cur_q <= cur_eff;
					res_q <= 32'(ipc_q);
					if (fin_q)
						fin_q <= 1'b0;
					else
						run_q <= run_q + 8'd1;
				end
			end
		end
	end

	assign status      = status_q;
	assign assigned_id = aid_q;
	assign action      = action_q;
	assign from_slot   = from_q;
	assign to_slot     = to_q;
	assign resume_pc   = res_q;
endmodule

/* hdl/rrts_ctrl.sv */
// Command sequencer for the scheduler.
module rrts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     cmd,
	input  rrts_pkg::sts_t sts,
	output rrts_pkg::ctl_t ctl,
	output logic           busy,
	output logic           done
);
	import rrts_pkg::*;

	fsm_t state_q, state_d;
	cmd_t cmd_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			cmd_q   <= CMD_TICK;
		end else begin
			state_q <= state_d;
			if (start && !busy)
				cmd_q <= cmd_t'(cmd);
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = (state_q != FSM_IDLE);
		done    = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					case (cmd_t'(cmd))
						CMD_ADD:    state_d = FSM_SCAN;
						CMD_REMOVE: state_d = FSM_SHIFT;
						CMD_DONE: begin
							ctl.done_set = 1'b1;
							state_d = FSM_DONE;
						end
						default:    state_d = FSM_TICK_RD;
					endcase
				end
			end
			FSM_SCAN: begin
				if (sts.full) begin
					ctl.add_write = 1'b1;
					state_d = FSM_DONE;
				end else if (cmd_q == CMD_ADD) begin
					// first pass tests requested id, then walks candidates
					ctl.scan_init = 1'b1;
					state_d = sts.id_hit ? FSM_TICK_RD : FSM_DONE;
					if (!sts.id_hit)
						ctl.add_write = 1'b0;
				end
			end
			default: ;
		endcase
		// Second-level handling kept in a separate case for clarity
		case (state_q)
			FSM_SHIFT: begin
				if (!sts.rm_valid) begin
					state_d = FSM_DONE;
				end else if (sts.shift_last) begin
					ctl.shift_end = 1'b1;
					state_d = FSM_DONE;
				end else begin
					ctl.shift_step = 1'b1;
				end
			end
			FSM_TICK_RD: begin
				if (cmd_q == CMD_ADD) begin
					// step candidates until a free id is found
					ctl.scan_step = 1'b1;
					if (!sts.id_hit) begin
						state_d = FSM_DONE;
					end
				end else begin
					ctl.tick_eval = 1'b1;
					state_d = FSM_DONE;
				end
			end
			FSM_DONE: begin
				done = 1'b1;
				state_d = FSM_IDLE;
			end
			default: ;
		endcase
		// Add writes once the id is settled
		if (cmd_q == CMD_ADD && !sts.full && state_d == FSM_DONE &&
		    (state_q == FSM_SCAN || state_q == FSM_TICK_RD))
			ctl.add_write = 1'b1;
	end
endmodule

/* hdl/round_robin_time_slice_scheduler.sv */
// Top level of the round-robin time-slice scheduler.
// Steps: done goes straight to its result; tick evaluates once; add tests the requested id,
// then steps past live candidate ids; remove shifts one entry per cycle up to the last live one.
// One request at a time; busy stays high through the result strobe and the next
// request is accepted the cycle after it. Results are valid on the one-cycle done strobe and
// hold until the next request is accepted; the receiver cannot stall.
// arst_n clears the table to all dead, counters to zero, kernel pc to zero.
module round_robin_time_slice_scheduler #(
	parameter int SLOTS   = 8,
	parameter int PC_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  cmd,
	input  logic [7:0]  task_id,
	input  logic [7:0]  slice_len,
	input  logic [31:0] entry_pc,
	input  logic [2:0]  slot,
	input  logic [31:0] interrupted_pc,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic [1:0]  status,
	output logic [7:0]  assigned_id,
	output logic [1:0]  action,
	output logic [2:0]  from_slot,
	output logic [2:0]  to_slot,
	output logic [31:0] resume_pc
);
	import rrts_pkg::*;

	ctl_t        ctl;
	sts_t        sts;
	logic [31:0] kpc_q;

	// Kernel return pc register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			kpc_q <= '0;
		else if (cfg_we)
			kpc_q <= cfg_wdata;
	end

	rrts_ctrl u_ctrl (
		.clk, .arst_n, .start, .cmd, .sts, .ctl, .busy, .done
	);

	rrts_datapath #(.SLOTS(SLOTS), .PC_BITS(PC_BITS)) u_dp (
		.clk, .arst_n, .ctl, .sts, .task_id, .slice_len, .entry_pc,
		.slot, .interrupted_pc, .kernel_return_pc(kpc_q), .status, .assigned_id,
		.action, .from_slot, .to_slot, .resume_pc
	);
endmodule

/* hdl/rrts_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
module rrts_assertions (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [1:0] action
);
	import rrts_pkg::*;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe outside a request");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request not busy");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK || action == ACT_NONE))
		else $error("add status and tick action both set");
endmodule

bind round_robin_time_slice_scheduler rrts_assertions u_chk (
	.clk, .arst_n, .start, .busy, .done, .status, .action
);

/* tb/rrts_checker.sv */
// Scoreboard for the scheduler: mirrors the task table, predicts each result and compares it.
module rrts_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [1:0]  cmd,
	input  logic [7:0]  task_id,
	input  logic [7:0]  slice_len,
	input  logic [31:0] entry_pc,
	input  logic [2:0]  slot,
	input  logic [31:0] interrupted_pc,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic [1:0]  status,
	input  logic [7:0]  assigned_id,
	input  logic [1:0]  action,
	input  logic [2:0]  from_slot,
	input  logic [2:0]  to_slot,
	input  logic [31:0] resume_pc,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;

	localparam int NUM_SLOTS = 8;

	typedef struct {
		status_t     stat;
		logic [7:0]  id;
		action_t     act;
		logic [2:0]  src;
		logic [2:0]  dst;
		logic [31:0] pc;
	} sched_result_t;

	ent_state_t  ent_st [NUM_SLOTS];
	logic [7:0]  ent_id [NUM_SLOTS];
	logic [7:0]  ent_slice [NUM_SLOTS];
	logic [31:0] ent_pc [NUM_SLOTS];
	int          live_count;
	int          run_slot;
	logic [7:0]  run_ticks;
	bit          finish_pending;
	logic [31:0] kernel_pc;
	sched_result_t expected_results[$];

	function automatic bit id_taken(logic [7:0] id);
		for (int i = 0; i < live_count; i++)
			if (ent_st[i] != ST_DEAD && ent_id[i] == id) return 1;
		return 0;
	endfunction

	function automatic logic [7:0] lowest_free_id();
		for (int c = 1; c < 256; c++)
			if (!id_taken(c[7:0])) return c[7:0];
		return 8'd0;
	endfunction

	// Apply one request to the mirrored table and return the expected result
	function automatic sched_result_t schedule_request(cmd_t c, logic [7:0] id,
			logic [7:0] slc, logic [31:0] epc, logic [2:0] sl, logic [31:0] ipc);
		sched_result_t r;
		int nxt;
		int rs;
		r = '{STAT_OK, 8'd0, ACT_NONE, 3'd0, 3'd0, 32'd0};
		case (c)
			CMD_ADD: begin
				if (live_count >= NUM_SLOTS) begin
					r.stat = STAT_FULL;
				end else begin
					if (id_taken(id)) begin
						r.stat = STAT_REPLACED;
						id = lowest_free_id();
					end
					ent_st[live_count] = ST_INACTIVE;
					ent_id[live_count] = id;
					ent_slice[live_count] = slc;
					ent_pc[live_count] = epc;
					r.id = id;
					r.dst = live_count[2:0];
					live_count++;
				end
			end
			CMD_REMOVE: begin
				rs = sl;
				if (rs < live_count) begin
					run_ticks = FORCED_EXPIRY;
					for (int i = rs; i + 1 < live_count; i++) begin
						ent_st[i] = ent_st[i + 1];
						ent_id[i] = ent_id[i + 1];
						ent_slice[i] = ent_slice[i + 1];
						ent_pc[i] = ent_pc[i + 1];
					end
					live_count--;
					ent_st[live_count] = ST_DEAD;
					ent_id[live_count] = 8'd0;
					ent_slice[live_count] = 8'd0;
					ent_pc[live_count] = 32'd0;
					if (rs < run_slot) run_slot--;
					else if (rs == run_slot && run_slot >= live_count) run_slot = 0;
				end
			end
			CMD_DONE: finish_pending = 1;
			default: begin
				if (live_count == 0) begin
					r.act = ACT_KERNEL;
					r.pc = kernel_pc;
				end else begin
					if (run_slot >= live_count) run_slot = 0;
					r.pc = ipc;
					if (run_ticks >= ent_slice[run_slot]) begin
						// slice used up: rotate, start the current task, or keep a lone active task running
						run_ticks = 8'd0;
						nxt = run_slot + 1;
						if (nxt >= live_count) nxt = 0;
						if (ent_st[run_slot] == ST_ACTIVE && nxt != run_slot) begin
							ent_st[run_slot] = ST_WAITING;
							ent_pc[run_slot] = ipc;
							ent_st[nxt] = ST_ACTIVE;
							r.act = ACT_SWITCH;
							r.src = run_slot[2:0];
							r.dst = nxt[2:0];
							r.pc = ent_pc[nxt];
							run_slot = nxt;
						end else if (ent_st[run_slot] != ST_ACTIVE) begin
							ent_st[run_slot] = ST_ACTIVE;
							r.act = ACT_START;
							r.dst = run_slot[2:0];
							r.pc = ent_pc[run_slot];
						end
					end else if (finish_pending) begin
						finish_pending = 0;
					end else begin
						run_ticks = run_ticks + 8'd1;
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ent_st[i] = ST_DEAD;
				ent_id[i] = 8'd0;
				ent_slice[i] = 8'd0;
				ent_pc[i] = 32'd0;
			end
			live_count = 0;
			run_slot = 0;
			run_ticks = 8'd0;
			finish_pending = 0;
			kernel_pc = 32'd0;
			expected_results.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) kernel_pc = cfg_wdata;
			// predict each accepted request
			if (start && !busy)
				expected_results.push_back(schedule_request(cmd_t'(cmd), task_id, slice_len,
					entry_pc, slot, interrupted_pc));
			// compare each strobed result with the oldest prediction
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result status=%0d id=%0d action=%0d",
						$realtime, status, assigned_id, action);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.stat || assigned_id !== e.id || action !== e.act ||
							from_slot !== e.src || to_slot !== e.dst || resume_pc !== e.pc) begin
						$display("%0t: mismatch expected st=%0d id=%0d act=%0d from=%0d to=%0d pc=%h",
							$realtime, e.stat, e.id, e.act, e.src, e.dst, e.pc);
						$display("%0t:          actual   st=%0d id=%0d act=%0d from=%0d to=%0d pc=%h",
							$realtime, status, assigned_id, action, from_slot, to_slot, resume_pc);
						fail_count <= fail_count + 1;
					end
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

/* tb/tb_round_robin_time_slice_scheduler.sv */
// Testbench top for the scheduler: clock, reset, request stimulus and verdict.
module tb_round_robin_time_slice_scheduler;
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy, done;
	logic [1:0]  cmd = CMD_TICK;
	logic [7:0]  task_id = 0, slice_len = 0;
	logic [31:0] entry_pc = 0, interrupted_pc = 0;
	logic [2:0]  slot = 0;
	logic        cfg_we = 0;
	logic [31:0] cfg_wdata = 0;
	logic [1:0]  status, action;
	logic [7:0]  assigned_id;
	logic [2:0]  from_slot, to_slot;
	logic [31:0] resume_pc;
	int          fail_count, outstanding;
	int          idle_cycles = 0;

	round_robin_time_slice_scheduler dut (.*);

	rrts_checker checker_i (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// Drive one request and hold it until accepted; start stays high on return
	task automatic send_request(cmd_t c, logic [7:0] id, logic [7:0] slc,
			logic [31:0] epc, logic [2:0] sl, logic [31:0] ipc);
		cmd <= c;
		task_id <= id;
		slice_len <= slc;
		entry_pc <= epc;
		slot <= sl;
		interrupted_pc <= ipc;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Drop start, drain all predictions, settle, then write the kernel pc
	task automatic write_kernel_pc(logic [31:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request();
		int pick;
		logic [7:0] slc;
		logic [7:0] id;
		pick = $urandom_range(0, 99);
		slc = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
		if (pick < 50)
			send_request(CMD_TICK, 8'($urandom), 8'($urandom), $urandom, 3'($urandom), $urandom);
		else if (pick < 72)
			send_request(CMD_ADD, id, slc, $urandom, 3'($urandom), $urandom);
		else if (pick < 87)
			send_request(CMD_REMOVE, 8'($urandom), 8'($urandom), $urandom,
				3'($urandom), $urandom);
		else
			send_request(CMD_DONE, 8'($urandom), 8'($urandom), $urandom, 3'($urandom), $urandom);
	endtask

	// Watchdog: end the run when no request is accepted and no result strobed for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int burst;
		int drain;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, id collisions, full table, expiry paths
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'hFFFF_FFFF);
		send_request(CMD_REMOVE, 8'd0, 8'd0, 32'd0, 3'd0, 32'd0);
		write_kernel_pc(32'hFFFF_FFFF);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd7, 32'h0);
		send_request(CMD_ADD, 8'd0, 8'd0, 32'hFFFF_FFFF, 3'd0, 32'd0);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'h1234_5678);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'hFFFF_FFFF);
		send_request(CMD_ADD, 8'd0, 8'd255, 32'h0, 3'd0, 32'd0);
		send_request(CMD_ADD, 8'd255, 8'd1, 32'hA5A5_5A5A, 3'd0, 32'd0);
		send_request(CMD_ADD, 8'd255, 8'd0, 32'h5A5A_A5A5, 3'd0, 32'd0);
		send_request(CMD_ADD, 8'd1, 8'd2, 32'h0000_1000, 3'd0, 32'd0);
		send_request(CMD_ADD, 8'd128, 8'd0, 32'h0000_2000, 3'd0, 32'd0);
		send_request(CMD_ADD, 8'd7, 8'd1, 32'h0000_3000, 3'd0, 32'd0);
		send_request(CMD_ADD, 8'd7, 8'd0, 32'h0000_4000, 3'd0, 32'd0);
		send_request(CMD_ADD, 8'd9, 8'd0, 32'h0000_5000, 3'd0, 32'd0);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'hDEAD_BEEF);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'hCAFE_F00D);
		send_request(CMD_DONE, 8'd0, 8'd0, 32'd0, 3'd0, 32'd0);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'h0BAD_0001);
		send_request(CMD_REMOVE, 8'd0, 8'd0, 32'd0, 3'd7, 32'd0);
		send_request(CMD_REMOVE, 8'd0, 8'd0, 32'd0, 3'd7, 32'd0);
		send_request(CMD_REMOVE, 8'd0, 8'd0, 32'd0, 3'd0, 32'd0);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'h0000_0042);
		send_request(CMD_TICK, 8'd0, 8'd0, 32'd0, 3'd0, 32'h0000_0043);

		// random phases, each starting from a new kernel pc
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_kernel_pc(32'h0);
				4: write_kernel_pc(32'hFFFF_FFFF);
				default: write_kernel_pc($urandom);
			endcase
			for (int n = 0; n < 190; ) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst; b++) begin
					random_request();
					n++;
				end
				// gap between bursts, or none at all
				if ($urandom_range(0, 2) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end

		start <= 1'b0;
		drain = 0;
		@(posedge clk);
		while ((outstanding != 0 || busy) && drain < STALL_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
